// File: design/delta_timer_queue_assert.svh
// assertion macros for the delta timer queue
// used by the port checker, no other dependencies
`ifndef DELTA_TIMER_QUEUE_ASSERT_SVH
`define DELTA_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DTQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dtq_pkg.sv
// shared types and codes for the delta timer queue
// no dependencies
package dtq_pkg;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  localparam int MAX_RESULTS = 16;
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam int DELTA_W = 31;
  localparam int ID_W = 32;
  localparam int TAG_W = 8;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [DELTA_W-1:0] timeout_ticks;
    logic [TAG_W-1:0]   dest_port;
    logic [ID_W-1:0]    target_id;
  } req_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [ID_W-1:0]  timer_id;
    logic [TAG_W-1:0] notify_port;
    logic             success;
    logic             last_of_run;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // take item, start walk at head
    logic walk_adv;     // step to next entry
    logic c_split;      // shorten successor of new entry
    logic c_write_new;  // write new entry into free slot
    logic c_commit;     // link in new entry, answer create
    logic c_fail;       // answer create with failure
    logic r_save;       // remember victim, move to successor
    logic r_merge;      // give victim delta to successor
    logic r_commit;     // unlink victim, answer remove
    logic r_fail;       // answer remove with failure
    logic t_dec;        // count head down
    logic t_pop;        // take head off the list
    logic exp_emit;     // send captured expiry
    logic exp_last;     // expiry is the final result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       full;
    logic       at_end;
    logic       count_zero;
    logic       delta_gt_rem;
    logic       ident_match;
    logic       nxt_valid;
    logic       dec_zero;
    logic       head_zero;
    logic       n_max;
    logic       out_free;
  } stat_t;

endpackage

// File: design/dtq_ram.sv
// generic single write, single read memory with registered read
// no dependencies
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dtq_datapath.sv
// datapath of the delta timer queue: slot memories, list registers, result register
// depends on dtq_pkg and dtq_ram
module dtq_datapath #(
  parameter int MAX_TIMERS = 16,
  parameter int PORT_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  dtq_pkg::req_t req,
  input  dtq_pkg::cmd_t cmd,
  output dtq_pkg::stat_t stat,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dtq_pkg::rsp_t rsp
);

  localparam int SW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int DW = dtq_pkg::DELTA_W;
  localparam int IW = dtq_pkg::ID_W;
  localparam int TW = dtq_pkg::TAG_W;

  logic [PORT_BITS-1:0] port;
  logic [IW-1:0]        target;
  logic [SW-1:0]        cur, prev, new_link, victim, head;
  logic                 has_prev;
  logic [CW-1:0]        idx, count;
  logic [DW-1:0]        rem, saved;
  logic [MAX_TIMERS-1:0] used;
  logic [IW-1:0]        id_ctr;
  logic [dtq_pkg::NW-1:0] n;
  logic [IW-1:0]        cap_ident;
  logic [PORT_BITS-1:0] cap_port;

  logic [IW-1:0]        r_ident;
  logic [PORT_BITS-1:0] r_port;
  logic [DW-1:0]        r_delta;
  logic [SW-1:0]        r_link;

  logic [SW-1:0]        free_slot;
  logic [PORT_BITS-1:0] in_port;
  logic [TW-1:0]        out_port;
  logic [DW-1:0]        d_dec;

  logic                 delta_we, link_we;
  logic [SW-1:0]        delta_wa, link_wa;
  logic [DW-1:0]        delta_wd;
  logic [SW-1:0]        link_wd;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  // tag width conversions
  always_comb begin
    for (int i = 0; i < PORT_BITS; i++) begin
      in_port[i] = (i < TW) ? req.dest_port[i % TW] : 1'b0;
    end
    for (int i = 0; i < TW; i++) begin
      out_port[i] = (i < PORT_BITS) ? cap_port[i % PORT_BITS] : 1'b0;
    end
  end

  assign d_dec = (r_delta == '0) ? '0 : r_delta - DW'(1);

  always_comb begin
    delta_we = 1'b0;
    delta_wa = cur;
    delta_wd = d_dec;
    if (cmd.c_split) begin
      delta_we = 1'b1;
      delta_wd = r_delta - rem;
    end else if (cmd.c_write_new) begin
      delta_we = 1'b1;
      delta_wa = free_slot;
      delta_wd = rem;
    end else if (cmd.r_merge) begin
      delta_we = 1'b1;
      delta_wd = r_delta + saved;
    end else if (cmd.t_dec) begin
      delta_we = 1'b1;
    end
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = prev;
    link_wd = cur;
    if (cmd.c_write_new) begin
      link_we = 1'b1;
      link_wa = free_slot;
      link_wd = new_link;
    end else if (cmd.c_commit) begin
      link_we = has_prev;
      link_wd = free_slot;
    end else if (cmd.r_commit) begin
      link_we = has_prev;
    end
  end

  dtq_ram #(.WIDTH(IW), .DEPTH(MAX_TIMERS)) u_ident (
    .clk(clk), .we(cmd.c_write_new), .waddr(free_slot), .wdata(id_ctr + IW'(1)),
    .raddr(cur), .rdata(r_ident)
  );
  dtq_ram #(.WIDTH(PORT_BITS), .DEPTH(MAX_TIMERS)) u_port (
    .clk(clk), .we(cmd.c_write_new), .waddr(free_slot), .wdata(port),
    .raddr(cur), .rdata(r_port)
  );
  dtq_ram #(.WIDTH(DW), .DEPTH(MAX_TIMERS)) u_delta (
    .clk(clk), .we(delta_we), .waddr(delta_wa), .wdata(delta_wd),
    .raddr(cur), .rdata(r_delta)
  );
  dtq_ram #(.WIDTH(SW), .DEPTH(MAX_TIMERS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(cur), .rdata(r_link)
  );

  always_comb begin
    stat.in_op        = req.opcode;
    stat.full         = (count >= CW'(MAX_TIMERS));
    stat.at_end       = (idx == count);
    stat.count_zero   = (count == '0);
    stat.delta_gt_rem = (r_delta > rem);
    stat.ident_match  = (r_ident == target);
    stat.nxt_valid    = ((idx + CW'(1)) < count);
    stat.dec_zero     = (d_dec == '0);
    stat.head_zero    = (r_delta == '0);
    stat.n_max        = (n == dtq_pkg::NW'(dtq_pkg::MAX_RESULTS));
    stat.out_free     = !rsp_valid || rsp_ready;
  end

  // list walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      port     <= in_port;
      target   <= req.target_id;
      cur      <= head;
      rem      <= req.timeout_ticks;
      idx      <= '0;
      has_prev <= 1'b0;
      new_link <= '0;
    end
    if (cmd.walk_adv) begin
      rem      <= rem - r_delta;
      prev     <= cur;
      has_prev <= 1'b1;
      cur      <= r_link;
      idx      <= idx + CW'(1);
    end
    if (cmd.c_split) begin
      new_link <= cur;
    end
    if (cmd.r_save) begin
      victim <= cur;
      saved  <= r_delta;
      cur    <= r_link;
    end
    if (cmd.t_pop) begin
      cap_ident <= r_ident;
      cap_port  <= r_port;
      cur       <= r_link;
    end
  end

  // list control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      head   <= '0;
      count  <= '0;
      id_ctr <= '0;
      n      <= '0;
    end else begin
      if (cmd.load) begin
        n <= '0;
      end
      if (cmd.c_commit) begin
        used[free_slot] <= 1'b1;
        count           <= count + CW'(1);
        id_ctr          <= id_ctr + IW'(1);
        if (!has_prev) begin
          head <= free_slot;
        end
      end
      if (cmd.r_commit) begin
        used[victim] <= 1'b0;
        count        <= count - CW'(1);
        if (!has_prev) begin
          head <= cur;
        end
      end
      if (cmd.t_pop) begin
        used[cur] <= 1'b0;
        count     <= count - CW'(1);
        n         <= n + dtq_pkg::NW'(1);
        head      <= (count == CW'(1)) ? '0 : r_link;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.c_commit || cmd.c_fail || cmd.r_commit || cmd.r_fail || cmd.exp_emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.c_commit || cmd.c_fail) begin
      rsp.result_kind <= dtq_pkg::KIND_CREATE;
      rsp.timer_id    <= cmd.c_commit ? id_ctr + IW'(1) : '0;
      rsp.notify_port <= '0;
      rsp.success     <= cmd.c_commit;
      rsp.last_of_run <= 1'b1;
    end else if (cmd.r_commit || cmd.r_fail) begin
      rsp.result_kind <= dtq_pkg::KIND_REMOVE;
      rsp.timer_id    <= target;
      rsp.notify_port <= '0;
      rsp.success     <= cmd.r_commit;
      rsp.last_of_run <= 1'b1;
    end else if (cmd.exp_emit) begin
      rsp.result_kind <= dtq_pkg::KIND_EXPIRE;
      rsp.timer_id    <= cap_ident;
      rsp.notify_port <= out_port;
      rsp.success     <= 1'b1;
      rsp.last_of_run <= cmd.exp_last;
    end
  end

endmodule

// File: design/dtq_ctrl.sv
// controller of the delta timer queue: sequences create, remove and tick
// depends on dtq_pkg
module dtq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dtq_pkg::stat_t stat,
  output dtq_pkg::cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_C_RD     = 16'h0002,
    S_C_EV     = 16'h0004,
    S_C_NEW    = 16'h0008,
    S_C_COMMIT = 16'h0010,
    S_C_FAIL   = 16'h0020,
    S_R_RD     = 16'h0040,
    S_R_EV     = 16'h0080,
    S_R_NRD    = 16'h0100,
    S_R_NEV    = 16'h0200,
    S_R_COMMIT = 16'h0400,
    S_R_FAIL   = 16'h0800,
    S_T_RD     = 16'h1000,
    S_T_DEC    = 16'h2000,
    S_T_NRD    = 16'h4000,
    S_T_NEV    = 16'h8000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          case (stat.in_op)
            dtq_pkg::OP_CREATE: state_next = stat.full ? S_C_FAIL : S_C_RD;
            dtq_pkg::OP_REMOVE: state_next = S_R_RD;
            dtq_pkg::OP_TICK:   state_next = S_T_RD;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_C_RD: state_next = stat.at_end ? S_C_NEW : S_C_EV;
      S_C_EV: begin
        if (stat.delta_gt_rem) begin
          cmd.c_split = 1'b1;
          state_next = S_C_NEW;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next = S_C_RD;
        end
      end
      S_C_NEW: begin
        cmd.c_write_new = 1'b1;
        state_next = S_C_COMMIT;
      end
      S_C_COMMIT: begin
        if (stat.out_free) begin
          cmd.c_commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_C_FAIL: begin
        if (stat.out_free) begin
          cmd.c_fail = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_R_RD: state_next = stat.at_end ? S_R_FAIL : S_R_EV;
      S_R_EV: begin
        if (stat.ident_match) begin
          cmd.r_save = 1'b1;
          state_next = stat.nxt_valid ? S_R_NRD : S_R_COMMIT;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next = S_R_RD;
        end
      end
      S_R_NRD: state_next = S_R_NEV;
      S_R_NEV: begin
        cmd.r_merge = 1'b1;
        state_next = S_R_COMMIT;
      end
      S_R_COMMIT: begin
        if (stat.out_free) begin
          cmd.r_commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_R_FAIL: begin
        if (stat.out_free) begin
          cmd.r_fail = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_T_RD: state_next = stat.count_zero ? S_IDLE : S_T_DEC;
      S_T_DEC: begin
        cmd.t_dec = 1'b1;
        if (stat.dec_zero) begin
          cmd.t_pop = 1'b1;
          state_next = S_T_NRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_T_NRD: begin
        if (stat.count_zero || stat.n_max) begin
          if (stat.out_free) begin
            cmd.exp_emit = 1'b1;
            cmd.exp_last = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_T_NEV;
        end
      end
      S_T_NEV: begin
        if (stat.out_free) begin
          cmd.exp_emit = 1'b1;
          if (stat.head_zero) begin
            cmd.t_pop = 1'b1;
            state_next = S_T_NRD;
          end else begin
            cmd.exp_last = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/delta_timer_queue.sv
// top level of the delta timer queue
// depends on dtq_pkg, dtq_ctrl, dtq_datapath (and dtq_ram below it)
//
// usage
//  - req channel (req_valid/req_ready/req) carries create, remove and tick
//    operations; rsp channel (rsp_valid/rsp_ready/rsp) returns answers
//  - create and remove give exactly one result; tick gives zero to sixteen
//    expiry results, the final one marked by last_of_run
//  - one operation at a time: req_ready is high only while no operation
//    is in flight
//  - create and remove walk the list entry by entry, with a read step and
//    an evaluate step for each entry visited, then give their answer
//  - tick counts the head down, if there is one, then takes off and reports
//    each entry that expires, in turn; the walk goes over the slot memory,
//    one read port with a registered read
//  - results leave through a result register; a stalled receiver holds the
//    sequencer in its emitting step, nothing is dropped
//  - reset empties the list and clears the identifier counter at once;
//    slot memories need no clearing since only linked slots are read
module delta_timer_queue #(
  parameter int MAX_TIMERS = 16,
  parameter int PORT_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dtq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dtq_pkg::rsp_t rsp
);

  dtq_pkg::cmd_t  cmd;   // sequencer commands
  dtq_pkg::stat_t stat;  // compares and flags from the list

  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtq_datapath #(
    .MAX_TIMERS (MAX_TIMERS),
    .PORT_BITS  (PORT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: design/dtq_checker.sv
// port level checks for the delta timer queue, bound to the top level
// depends on dtq_pkg and delta_timer_queue_assert.svh
`include "delta_timer_queue_assert.svh"

module dtq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input dtq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input dtq_pkg::rsp_t rsp
);

  `DTQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
  `DTQ_ASSERT_IMPLY(a_answer_last, rsp_valid && (rsp.result_kind != dtq_pkg::KIND_EXPIRE), rsp.last_of_run, "answer not final")
  `DTQ_ASSERT_IMPLY(a_expire_ok, rsp_valid && (rsp.result_kind == dtq_pkg::KIND_EXPIRE), rsp.success, "expiry without success")
  `DTQ_ASSERT_NEXT(a_busy, req_valid && req_ready && (req.opcode == dtq_pkg::OP_CREATE || req.opcode == dtq_pkg::OP_REMOVE || req.opcode == dtq_pkg::OP_TICK), !req_ready, "ready while busy")

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (.*);

// File: test/tb_delta_timer_queue.sv
// self-checking testbench for the delta timer queue
// drives create, remove and tick operations and checks every result transfer
// depends on dtq_pkg and delta_timer_queue
`timescale 1ns / 1ps

module tb_delta_timer_queue;

  localparam int SLOTS = 16;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM = 110;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  dtq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  dtq_pkg::rsp_t rsp;

  bit failed = 1'b0;
  bit quiet = 1'b0;        // no idling in the last part of the run
  bit stim_done = 1'b0;

  // shadow copy of the queue
  logic [dtq_pkg::ID_W-1:0]    q_ident [SLOTS];
  logic [dtq_pkg::TAG_W-1:0]   q_port  [SLOTS];
  logic [dtq_pkg::DELTA_W-1:0] q_delta [SLOTS];
  logic [3:0]                  q_link  [SLOTS];
  bit                          q_used  [SLOTS];
  logic [3:0]                  q_head;
  int                          q_count;
  logic [dtq_pkg::ID_W-1:0]    q_idctr;

  dtq_pkg::rsp_t pending_rsp[$];

  // directed table; has_exp marks rows whose answer is typed in
  typedef struct {
    dtq_pkg::req_t item;
    bit            has_exp;
    dtq_pkg::rsp_t exp;
  } dir_row_t;
  dir_row_t dir_tab [N_DIRECTED];

  delta_timer_queue dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic dtq_pkg::rsp_t mk_rsp(logic [1:0] kind, logic [dtq_pkg::ID_W-1:0] id,
                                           logic [dtq_pkg::TAG_W-1:0] port, logic ok,
                                           logic last);
    dtq_pkg::rsp_t r;
    r.result_kind = kind;
    r.timer_id = id;
    r.notify_port = port;
    r.success = ok;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic dtq_pkg::req_t mk_req(logic [1:0] op, logic [dtq_pkg::DELTA_W-1:0] to,
                                           logic [dtq_pkg::TAG_W-1:0] port,
                                           logic [dtq_pkg::ID_W-1:0] tid);
    dtq_pkg::req_t r;
    r.opcode = op;
    r.timeout_ticks = to;
    r.dest_port = port;
    r.target_id = tid;
    return r;
  endfunction

  // advance the shadow queue by one operation, returning the answers it causes
  task automatic queue_predict(input dtq_pkg::req_t it, output dtq_pkg::rsp_t outs[$]);
    logic [dtq_pkg::DELTA_W-1:0] rem;
    logic [3:0] cur, prv, nxt, h;
    bit has_prv, placed;
    int s, n;
    outs = {};
    case (it.opcode)
      dtq_pkg::OP_CREATE: begin
        s = -1;
        for (int k = SLOTS - 1; k >= 0; k--) if (!q_used[k]) s = k;
        if (q_count >= SLOTS || s < 0) begin
          outs.push_back(mk_rsp(dtq_pkg::KIND_CREATE, '0, '0, 1'b0, 1'b1));
        end else begin
          q_idctr = q_idctr + 32'd1;
          q_ident[s] = q_idctr;
          q_port[s] = it.dest_port;
          q_used[s] = 1'b1;
          rem = it.timeout_ticks;
          cur = q_head;
          has_prv = 0;
          placed = 0;
          prv = '0;
          for (int i = 0; i < q_count; i++) begin
            if (q_delta[cur] > rem) begin
              q_delta[cur] = q_delta[cur] - rem;
              q_link[s] = cur;
              placed = 1;
              break;
            end
            rem = rem - q_delta[cur];
            prv = cur;
            has_prv = 1;
            cur = q_link[cur];
          end
          if (!placed) q_link[s] = '0;
          q_delta[s] = rem;
          if (has_prv) q_link[prv] = s[3:0];
          else q_head = s[3:0];
          q_count++;
          outs.push_back(mk_rsp(dtq_pkg::KIND_CREATE, q_idctr, '0, 1'b1, 1'b1));
        end
      end
      dtq_pkg::OP_REMOVE: begin
        cur = q_head;
        has_prv = 0;
        placed = 0;
        prv = '0;
        for (int i = 0; i < q_count; i++) begin
          if (q_ident[cur] == it.target_id) begin
            nxt = q_link[cur];
            if (i + 1 < q_count) q_delta[nxt] = q_delta[nxt] + q_delta[cur];
            if (has_prv) q_link[prv] = nxt;
            else q_head = nxt;
            q_used[cur] = 0;
            q_count--;
            placed = 1;
            break;
          end
          prv = cur;
          has_prv = 1;
          cur = q_link[cur];
        end
        outs.push_back(mk_rsp(dtq_pkg::KIND_REMOVE, it.target_id, '0, placed, 1'b1));
      end
      dtq_pkg::OP_TICK: begin
        if (q_count > 0) begin
          if (q_delta[q_head] > 0) q_delta[q_head] = q_delta[q_head] - 31'd1;
          n = 0;
          while (q_count > 0 && q_delta[q_head] == 0 && n < dtq_pkg::MAX_RESULTS) begin
            h = q_head;
            outs.push_back(mk_rsp(dtq_pkg::KIND_EXPIRE, q_ident[h], q_port[h], 1'b1, 1'b0));
            n++;
            q_used[h] = 0;
            q_head = q_link[h];
            q_count--;
          end
          if (q_count == 0) q_head = '0;
          if (n > 0) outs[n-1].last_of_run = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // one request transfer, with a random idle burst in front
  task automatic send_item(input dtq_pkg::req_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // predict and send; the answers are queued as expected results, so the queue state stays in step
  task automatic run_item(input dtq_pkg::req_t it, input bit has_exp, input dtq_pkg::rsp_t exp);
    dtq_pkg::rsp_t outs[$];
    queue_predict(it, outs);
    if (has_exp && (outs.size() != 1 || outs[0] !== exp)) begin
      $display("%0t directed row table mismatch: expected %h predicted %h",
               $time, exp, outs.size() ? outs[0] : '0);
      failed = 1'b1;
    end
    foreach (outs[k]) pending_rsp.push_back(outs[k]);
    send_item(it);
  endtask

  // receiver: random stall bursts, checks each result transfer field by field
  initial begin
    dtq_pkg::rsp_t e;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, rsp);
          failed = 1'b1;
        end else begin
          e = pending_rsp.pop_front();
          if (rsp.result_kind !== e.result_kind) begin
            $display("%0t result_kind: expected %0d actual %0d", $time,
                     e.result_kind, rsp.result_kind);
            failed = 1'b1;
          end
          if (rsp.timer_id !== e.timer_id) begin
            $display("%0t timer_id: expected %h actual %h", $time, e.timer_id, rsp.timer_id);
            failed = 1'b1;
          end
          if (rsp.notify_port !== e.notify_port) begin
            $display("%0t notify_port: expected %h actual %h", $time,
                     e.notify_port, rsp.notify_port);
            failed = 1'b1;
          end
          if (rsp.success !== e.success) begin
            $display("%0t success: expected %b actual %b", $time, e.success, rsp.success);
            failed = 1'b1;
          end
          if (rsp.last_of_run !== e.last_of_run) begin
            $display("%0t last_of_run: expected %b actual %b", $time,
                     e.last_of_run, rsp.last_of_run);
            failed = 1'b1;
          end
        end
      end
      // random stall bursts, none once the run winds down
      if (stall > 0) begin
        stall--;
        rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // random operation: creates, removes, ticks and a rare unused opcode; timeouts mostly short, ids mostly recent
  function automatic dtq_pkg::req_t rand_item();
    dtq_pkg::req_t r;
    int pick;
    logic [dtq_pkg::DELTA_W-1:0] to;
    logic [dtq_pkg::ID_W-1:0] tid;
    pick = $urandom_range(0, 99);
    to = dtq_pkg::DELTA_W'($urandom);
    case ($urandom_range(0, 9))
      0: ;                                  // full range timeout
      1: to = '0;
      default: to = dtq_pkg::DELTA_W'($urandom_range(0, 6));
    endcase
    tid = $urandom;
    if ($urandom_range(0, 3) != 0) tid = q_idctr - $urandom_range(0, 20);
    if (pick < 40) r = mk_req(dtq_pkg::OP_CREATE, to, dtq_pkg::TAG_W'($urandom), tid);
    else if (pick < 60) r = mk_req(dtq_pkg::OP_REMOVE, to, dtq_pkg::TAG_W'($urandom), tid);
    else if (pick < 97) r = mk_req(dtq_pkg::OP_TICK, to, dtq_pkg::TAG_W'($urandom), tid);
    else r = mk_req(2'd3, to, dtq_pkg::TAG_W'($urandom), tid);   // unused opcode, no effect
    return r;
  endfunction

  initial begin
    dtq_pkg::rsp_t none;
    int row;
    none = '0;
    for (int k = 0; k < SLOTS; k++) q_used[k] = 0;
    q_head = '0;
    q_count = 0;
    q_idctr = '0;

    // directed table: empty-list cases, field extremes, an unused opcode, many expiries
    row = 0;
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_TICK, '1, '1, '1), 0, none};   // tick on empty list
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_REMOVE, '0, '0, '0), 1,        // remove on empty list
                       mk_rsp(dtq_pkg::KIND_REMOVE, '0, '0, 1'b0, 1'b1)};
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_REMOVE, '1, '1, '1), 1,
                       mk_rsp(dtq_pkg::KIND_REMOVE, '1, '0, 1'b0, 1'b1)};
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_CREATE, '0, '0, '0), 1,        // first id is one
                       mk_rsp(dtq_pkg::KIND_CREATE, 32'd1, '0, 1'b1, 1'b1)};
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_CREATE, '1, '1, '1), 1,        // largest timeout
                       mk_rsp(dtq_pkg::KIND_CREATE, 32'd2, '0, 1'b1, 1'b1)};
    dir_tab[row++] = '{mk_req(2'd3, '1, '1, '1), 0, none};               // unused opcode
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_TICK, '0, '0, '0), 0, none};   // zero timeout expires
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_REMOVE, '0, '0, 32'd2), 1,
                       mk_rsp(dtq_pkg::KIND_REMOVE, 32'd2, '0, 1'b1, 1'b1)};
    // thirteen equal timeouts, all expire on one tick
    for (int k = 0; k < 13; k++)
      dir_tab[row++] = '{mk_req(dtq_pkg::OP_CREATE, 31'd1, k[7:0] ^ 8'hA5, '0), 0, none};
    dir_tab[row++] = '{mk_req(dtq_pkg::OP_TICK, '0, '0, '0), 0, none};
    for (; row < N_DIRECTED; )
      dir_tab[row++] = '{mk_req(dtq_pkg::OP_TICK, '0, '0, '0), 0, none};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) run_item(dir_tab[k].item, dir_tab[k].has_exp, dir_tab[k].exp);
    // fill to capacity then overflow, then one tick releases a run of sixteen
    while (q_count < SLOTS)
      run_item(mk_req(dtq_pkg::OP_CREATE, 31'd1, dtq_pkg::TAG_W'($urandom), '0), 0, none);
    run_item(mk_req(dtq_pkg::OP_CREATE, 31'd3, '0, '0), 1,
             mk_rsp(dtq_pkg::KIND_CREATE, '0, '0, 1'b0, 1'b1));
    run_item(mk_req(dtq_pkg::OP_TICK, '0, '0, '0), 0, none);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 20) quiet = 1'b1;
      run_item(rand_item(), 0, none);
    end
    // drain the queue: tick out short timers, remove long ones
    while (q_count > 0) begin
      if (q_delta[q_head] < 31'd8) run_item(mk_req(dtq_pkg::OP_TICK, '0, '0, '0), 0, none);
      else run_item(mk_req(dtq_pkg::OP_REMOVE, '0, '0, q_ident[q_head]), 0, none);
    end
    quiet = 1'b1;
    req_valid <= 1'b0;

    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && pending_rsp.size() == 0) begin
      $display("tb_delta_timer_queue passed");
    end else begin
      $display("tb_delta_timer_queue failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("tb_delta_timer_queue failed");
    $finish;
  end

endmodule

// File: delta_timer_queue.f
+incdir+design
design/dtq_pkg.sv
design/dtq_ram.sv
design/dtq_datapath.sv
design/dtq_ctrl.sv
design/delta_timer_queue.sv
design/dtq_checker.sv
test/tb_delta_timer_queue.sv
